// File: rtl/deadline_timer_heap_macros.svh
// ---------------------------------------------------------------------------
// Deadline timer heap assertion macros
// Shared forms for the concurrent assertions of the timer heap checker.
// ---------------------------------------------------------------------------
`ifndef DEADLINE_TIMER_HEAP_MACROS_SVH
`define DEADLINE_TIMER_HEAP_MACROS_SVH

// Same-cycle implication, sampled on clock and quiet during reset.
`define DTH_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("timer heap check failed");

// Next-cycle implication, sampled on clock and quiet during reset.
`define DTH_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("timer heap check failed");

`endif

// File: rtl/dth_pkg.sv
// ---------------------------------------------------------------------------
// Deadline timer heap package
// Defaults, result codes, action codes and sequencer states.
// ---------------------------------------------------------------------------
package dth_pkg;

   localparam int HEAP_DEPTH_DEF = 32;
   localparam int TIME_BITS_DEF  = 32;
   localparam int TAG_BITS_DEF   = 8;

   localparam logic ACT_PUSH    = 1'b0;
   localparam logic ACT_ADVANCE = 1'b1;

   typedef enum logic [2:0] {
      ST_EXPIRED   = 3'd0,
      ST_PUSH_OK   = 3'd1,
      ST_PUSH_PAST = 3'd2,
      ST_PUSH_FULL = 3'd3,
      ST_NONE_DUE  = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_PUSH_TEST,
      S_UP_TEST,
      S_UP_CMP,
      S_ADVANCE,
      S_CHECK,
      S_DN_LOAD,
      S_DN_READ,
      S_DN_PICK,
      S_DN_CMP,
      S_DONE
   } state_type;

   // One result handed from the sequencer to the output register.
   typedef struct packed {
      logic       valid;
      status_type status;
      logic       last;
   } emit_type;

endpackage

// File: rtl/deadline_timer_heap.sv
// ---------------------------------------------------------------------------
// Deadline timer heap
// Min-heap timer queue: pushes sift up, an advance expires due entries.
// ---------------------------------------------------------------------------
// The block takes one transaction at a time and holds req_stall high until
// its last result has been loaded into the output register. A push climbs
// at most log2(HEAP_DEPTH) heap levels before it settles, and a refused push
// does not touch the heap. An advance moves the clock forward, then for each
// expired entry refills the root from the last entry and sinks it, all paced
// by the single entry comparator and the one write port of the heap memory.
// Stalls on the result side hold the block longer. Each result carries the
// earliest deadline still held, all ones when the queue is empty.
module deadline_timer_heap #(
   parameter int HEAP_DEPTH = dth_pkg::HEAP_DEPTH_DEF,
   parameter int TIME_BITS  = dth_pkg::TIME_BITS_DEF,
   parameter int TAG_BITS   = dth_pkg::TAG_BITS_DEF,
   localparam int CNT_BITS  = $clog2(HEAP_DEPTH + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_action,
   input  logic [TIME_BITS-1:0] req_time_value,
   input  logic [TAG_BITS-1:0]  req_entry_tag,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [2:0]           rsp_status,
   output logic [TAG_BITS-1:0]  rsp_expired_tag,
   output logic [TIME_BITS-1:0] rsp_next_deadline,
   output logic [CNT_BITS-1:0]  rsp_entry_count,
   output logic                 rsp_last
);

   dth_pkg::emit_type    emit;
   logic [TAG_BITS-1:0]  emit_tag;
   logic [TIME_BITS-1:0] emit_deadline;
   logic [CNT_BITS-1:0]  emit_count;
   logic                 slot_free;

   logic                 rsp_valid_ff, rsp_valid_in;
   dth_pkg::status_type  rsp_status_ff;
   logic [TAG_BITS-1:0]  rsp_tag_ff;
   logic [TIME_BITS-1:0] rsp_deadline_ff;
   logic [CNT_BITS-1:0]  rsp_count_ff;
   logic                 rsp_last_ff;

   dth_core #(
      .HEAP_DEPTH (HEAP_DEPTH),
      .TIME_BITS  (TIME_BITS),
      .TAG_BITS   (TAG_BITS)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_time_value (req_time_value),
      .req_entry_tag  (req_entry_tag),
      .slot_free      (slot_free),
      .emit           (emit),
      .emit_tag       (emit_tag),
      .emit_deadline  (emit_deadline),
      .emit_count     (emit_count)
   );

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit.valid) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit.valid) begin
         rsp_status_ff   <= emit.status;
         rsp_tag_ff      <= emit_tag;
         rsp_deadline_ff <= emit_deadline;
         rsp_count_ff    <= emit_count;
         rsp_last_ff     <= emit.last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_expired_tag   = rsp_tag_ff;
   assign rsp_next_deadline = rsp_deadline_ff;
   assign rsp_entry_count   = rsp_count_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

// File: rtl/dth_cmp.sv
// ---------------------------------------------------------------------------
// Deadline timer heap compare unit
// Orders two (deadline, tag) entries: deadline first, smaller tag on a tie.
// ---------------------------------------------------------------------------
module dth_cmp #(
   parameter int TIME_BITS = dth_pkg::TIME_BITS_DEF,
   parameter int TAG_BITS  = dth_pkg::TAG_BITS_DEF
) (
   input  logic [TIME_BITS-1:0] a_time,
   input  logic [TAG_BITS-1:0]  a_tag,
   input  logic [TIME_BITS-1:0] b_time,
   input  logic [TAG_BITS-1:0]  b_tag,
   output logic                 a_less
);

   always_comb begin
      if (a_time != b_time) begin
         a_less = (a_time < b_time);
      end else begin
         a_less = (a_tag < b_tag);
      end
   end

endmodule

// File: rtl/dth_core.sv
// ---------------------------------------------------------------------------
// Deadline timer heap core
// Heap memory, sift sequencer and clock register around one compare unit.
// ---------------------------------------------------------------------------
module dth_core #(
   parameter int HEAP_DEPTH = dth_pkg::HEAP_DEPTH_DEF,
   parameter int TIME_BITS  = dth_pkg::TIME_BITS_DEF,
   parameter int TAG_BITS   = dth_pkg::TAG_BITS_DEF,
   localparam int CNT_BITS  = $clog2(HEAP_DEPTH + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_action,
   input  logic [TIME_BITS-1:0]  req_time_value,
   input  logic [TAG_BITS-1:0]   req_entry_tag,
   input  logic                  slot_free,
   output dth_pkg::emit_type     emit,
   output logic [TAG_BITS-1:0]   emit_tag,
   output logic [TIME_BITS-1:0]  emit_deadline,
   output logic [CNT_BITS-1:0]   emit_count
);

   localparam int IDX_BITS = $clog2(HEAP_DEPTH);
   localparam int CHW      = IDX_BITS + 2;

   // Heap storage, one write and two registered reads a cycle.
   logic [TIME_BITS-1:0] heap_time_mem [HEAP_DEPTH];
   logic [TAG_BITS-1:0]  heap_tag_mem  [HEAP_DEPTH];
   logic [TIME_BITS-1:0] rd0_time_ff, rd1_time_ff;
   logic [TAG_BITS-1:0]  rd0_tag_ff, rd1_tag_ff;

   dth_pkg::state_type   state_ff, state_in;
   dth_pkg::status_type  stat_ff, stat_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic [TIME_BITS-1:0] clk_ff, clk_in;
   logic [TIME_BITS-1:0] x_time_ff, x_time_in;
   logic [TAG_BITS-1:0]  x_tag_ff, x_tag_in;
   logic [IDX_BITS-1:0]  hole_ff, hole_in;
   logic [IDX_BITS-1:0]  child_idx_ff, child_idx_in;
   logic [TIME_BITS-1:0] child_time_ff, child_time_in;
   logic [TAG_BITS-1:0]  child_tag_ff, child_tag_in;
   logic                 pend_ff, pend_in;
   logic [TAG_BITS-1:0]  pend_tag_ff, pend_tag_in;
   logic [TIME_BITS-1:0] root_time_ff, root_time_in;
   logic [TAG_BITS-1:0]  root_tag_ff, root_tag_in;

   logic                 wr_en;
   logic [IDX_BITS-1:0]  wr_addr;
   logic [TIME_BITS-1:0] wr_time;
   logic [TAG_BITS-1:0]  wr_tag;
   logic [IDX_BITS-1:0]  rd0_addr, rd1_addr;

   logic [TIME_BITS-1:0] op_a_time, op_b_time;
   logic [TAG_BITS-1:0]  op_a_tag, op_b_tag;
   logic                 a_less;

   logic [IDX_BITS-1:0]  parent_idx;
   logic [CHW-1:0]       left_w, right_w, count_w;
   logic [CNT_BITS-1:0]  count_dec;
   logic                 due;

   dth_cmp #(
      .TIME_BITS (TIME_BITS),
      .TAG_BITS  (TAG_BITS)
   ) u_cmp (
      .a_time (op_a_time),
      .a_tag  (op_a_tag),
      .b_time (op_b_time),
      .b_tag  (op_b_tag),
      .a_less (a_less)
   );

   assign parent_idx = (hole_ff - IDX_BITS'(1)) >> 1;
   assign left_w     = {1'b0, hole_ff, 1'b1};
   assign right_w    = left_w + CHW'(1);
   assign count_w    = CHW'(count_ff);
   assign count_dec  = count_ff - CNT_BITS'(1);
   assign due        = (count_ff != '0) && !a_less;

   assign req_stall     = (state_ff != dth_pkg::S_IDLE);
   assign emit_deadline = (count_ff != '0) ? root_time_ff : '1;
   assign emit_count    = count_ff;

   // Compare operands follow the sequencer step.
   always_comb begin
      op_a_time = x_time_ff;
      op_a_tag  = x_tag_ff;
      op_b_time = rd0_time_ff;
      op_b_tag  = rd0_tag_ff;
      case (state_ff)
         dth_pkg::S_PUSH_TEST, dth_pkg::S_ADVANCE: begin
            op_a_time = clk_ff;
            op_a_tag  = '0;
            op_b_time = x_time_ff;
            op_b_tag  = '0;
         end
         dth_pkg::S_CHECK: begin
            op_a_time = clk_ff;
            op_a_tag  = '0;
            op_b_time = root_time_ff;
            op_b_tag  = '0;
         end
         dth_pkg::S_DN_PICK: begin
            op_a_time = rd1_time_ff;
            op_a_tag  = rd1_tag_ff;
         end
         dth_pkg::S_DN_CMP: begin
            op_a_time = child_time_ff;
            op_a_tag  = child_tag_ff;
            op_b_time = x_time_ff;
            op_b_tag  = x_tag_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      stat_in       = stat_ff;
      count_in      = count_ff;
      clk_in        = clk_ff;
      x_time_in     = x_time_ff;
      x_tag_in      = x_tag_ff;
      hole_in       = hole_ff;
      child_idx_in  = child_idx_ff;
      child_time_in = child_time_ff;
      child_tag_in  = child_tag_ff;
      pend_in       = pend_ff;
      pend_tag_in   = pend_tag_ff;
      wr_en         = 1'b0;
      wr_addr       = hole_ff;
      wr_time       = x_time_ff;
      wr_tag        = x_tag_ff;
      rd0_addr      = parent_idx;
      rd1_addr      = right_w[IDX_BITS-1:0];
      emit.valid    = 1'b0;
      emit.status   = stat_ff;
      emit.last     = 1'b1;
      emit_tag      = '0;

      case (state_ff)
         dth_pkg::S_IDLE: begin
            if (req_valid) begin
               x_time_in = req_time_value;
               x_tag_in  = req_entry_tag;
               pend_in   = 1'b0;
               state_in  = (req_action == dth_pkg::ACT_ADVANCE) ? dth_pkg::S_ADVANCE
                                                              : dth_pkg::S_PUSH_TEST;
            end
         end
         dth_pkg::S_PUSH_TEST: begin
            if (!a_less) begin
               stat_in  = dth_pkg::ST_PUSH_PAST;
               state_in = dth_pkg::S_DONE;
            end else if (count_ff == CNT_BITS'(HEAP_DEPTH)) begin
               stat_in  = dth_pkg::ST_PUSH_FULL;
               state_in = dth_pkg::S_DONE;
            end else begin
               hole_in  = count_ff[IDX_BITS-1:0];
               count_in = count_ff + CNT_BITS'(1);
               state_in = dth_pkg::S_UP_TEST;
            end
         end
         dth_pkg::S_UP_TEST: begin
            if (hole_ff == '0) begin
               wr_en    = 1'b1;
               stat_in  = dth_pkg::ST_PUSH_OK;
               state_in = dth_pkg::S_DONE;
            end else begin
               state_in = dth_pkg::S_UP_CMP;
            end
         end
         dth_pkg::S_UP_CMP: begin
            wr_en = 1'b1;
            if (a_less) begin
               // The parent moves down into the hole.
               wr_time  = rd0_time_ff;
               wr_tag   = rd0_tag_ff;
               hole_in  = parent_idx;
               state_in = dth_pkg::S_UP_TEST;
            end else begin
               stat_in  = dth_pkg::ST_PUSH_OK;
               state_in = dth_pkg::S_DONE;
            end
         end
         dth_pkg::S_ADVANCE: begin
            if (a_less) begin
               clk_in = x_time_ff;
            end
            state_in = dth_pkg::S_CHECK;
         end
         dth_pkg::S_CHECK: begin
            // A finished pop is reported here, once the next root is known.
            if ((pend_ff || !due) && !slot_free) begin
               state_in = dth_pkg::S_CHECK;
            end else begin
               emit.valid  = 1'b1;
               emit.status = pend_ff ? dth_pkg::ST_EXPIRED : dth_pkg::ST_NONE_DUE;
               emit.last   = !due;
               emit_tag    = pend_ff ? pend_tag_ff : '0;
               pend_in     = 1'b0;
               if (due) begin
                  emit.valid  = pend_ff;
                  pend_in     = 1'b1;
                  pend_tag_in = root_tag_ff;
                  count_in    = count_dec;
                  rd0_addr    = count_dec[IDX_BITS-1:0];
                  state_in    = (count_dec == '0) ? dth_pkg::S_CHECK : dth_pkg::S_DN_LOAD;
               end else begin
                  state_in = dth_pkg::S_IDLE;
               end
            end
         end
         dth_pkg::S_DN_LOAD: begin
            x_time_in = rd0_time_ff;
            x_tag_in  = rd0_tag_ff;
            hole_in   = '0;
            state_in  = dth_pkg::S_DN_READ;
         end
         dth_pkg::S_DN_READ: begin
            rd0_addr = left_w[IDX_BITS-1:0];
            if (left_w >= count_w) begin
               wr_en    = 1'b1;
               state_in = dth_pkg::S_CHECK;
            end else begin
               state_in = dth_pkg::S_DN_PICK;
            end
         end
         dth_pkg::S_DN_PICK: begin
            if ((right_w < count_w) && a_less) begin
               child_idx_in  = right_w[IDX_BITS-1:0];
               child_time_in = rd1_time_ff;
               child_tag_in  = rd1_tag_ff;
            end else begin
               child_idx_in  = left_w[IDX_BITS-1:0];
               child_time_in = rd0_time_ff;
               child_tag_in  = rd0_tag_ff;
            end
            state_in = dth_pkg::S_DN_CMP;
         end
         dth_pkg::S_DN_CMP: begin
            wr_en = 1'b1;
            if (a_less) begin
               wr_time  = child_time_ff;
               wr_tag   = child_tag_ff;
               hole_in  = child_idx_ff;
               state_in = dth_pkg::S_DN_READ;
            end else begin
               state_in = dth_pkg::S_CHECK;
            end
         end
         dth_pkg::S_DONE: begin
            if (slot_free) begin
               emit.valid = 1'b1;
               state_in   = dth_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = dth_pkg::S_IDLE;
         end
      endcase
   end

   // The root entry is mirrored in registers for the next deadline output.
   always_comb begin
      root_time_in = root_time_ff;
      root_tag_in  = root_tag_ff;
      if (wr_en && (wr_addr == '0)) begin
         root_time_in = wr_time;
         root_tag_in  = wr_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_time_mem[wr_addr] <= wr_time;
         heap_tag_mem[wr_addr]  <= wr_tag;
      end
      rd0_time_ff <= heap_time_mem[rd0_addr];
      rd0_tag_ff  <= heap_tag_mem[rd0_addr];
      rd1_time_ff <= heap_time_mem[rd1_addr];
      rd1_tag_ff  <= heap_tag_mem[rd1_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dth_pkg::S_IDLE;
         count_ff <= '0;
         clk_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         clk_ff   <= clk_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      stat_ff       <= stat_in;
      x_time_ff     <= x_time_in;
      x_tag_ff      <= x_tag_in;
      hole_ff       <= hole_in;
      child_idx_ff  <= child_idx_in;
      child_time_ff <= child_time_in;
      child_tag_ff  <= child_tag_in;
      pend_tag_ff   <= pend_tag_in;
      root_time_ff  <= root_time_in;
      root_tag_ff   <= root_tag_in;
   end

endmodule

// File: rtl/dth_checker.sv
// ---------------------------------------------------------------------------
// Deadline timer heap checker
// Port-level checks of the timer heap, attached to the top level by bind.
// ---------------------------------------------------------------------------
`include "deadline_timer_heap_macros.svh"

module dth_checker #(
   parameter int HEAP_DEPTH = dth_pkg::HEAP_DEPTH_DEF,
   parameter int TIME_BITS  = dth_pkg::TIME_BITS_DEF,
   parameter int TAG_BITS   = dth_pkg::TAG_BITS_DEF,
   localparam int CNT_BITS  = $clog2(HEAP_DEPTH + 1)
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 req_action,
   input logic [TIME_BITS-1:0] req_time_value,
   input logic [TAG_BITS-1:0]  req_entry_tag,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [2:0]           rsp_status,
   input logic [TAG_BITS-1:0]  rsp_expired_tag,
   input logic [TIME_BITS-1:0] rsp_next_deadline,
   input logic [CNT_BITS-1:0]  rsp_entry_count,
   input logic                 rsp_last
);

   logic [TAG_BITS+TIME_BITS+CNT_BITS+3:0] rsp_payload;
   logic                                   rsp_is_expiry;

   assign rsp_payload   = {rsp_status, rsp_expired_tag, rsp_next_deadline,
                           rsp_entry_count, rsp_last};
   assign rsp_is_expiry = (rsp_status == dth_pkg::ST_EXPIRED);

   // A stalled result holds its whole payload.
   `DTH_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))

   // The block works on one transaction at a time.
   `DTH_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)

   `DTH_ASSERT_NOW(a_count_range, rsp_valid, rsp_entry_count <= CNT_BITS'(HEAP_DEPTH))

   // An empty queue reports no deadline.
   `DTH_ASSERT_NOW(a_empty_deadline, rsp_valid && (rsp_entry_count == '0), rsp_next_deadline == '1)

   `DTH_ASSERT_NOW(a_tag_only_on_expiry, rsp_valid && !rsp_is_expiry, rsp_expired_tag == '0)

endmodule

bind deadline_timer_heap dth_checker #(
   .HEAP_DEPTH (HEAP_DEPTH),
   .TIME_BITS  (TIME_BITS),
   .TAG_BITS   (TAG_BITS)
) u_checker (.*);

// File: verif/deadline_timer_heap_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Deadline timer heap testbench
// Drives pushes and clock advances through the valid/stall request channel,
// keeps an ordered list of held timers to predict every result, and checks
// each result transaction field by field under random sender gaps and
// receiver stalls, including one long receiver hold-off.
// ---------------------------------------------------------------------------
module deadline_timer_heap_test;

   localparam int DEPTH       = dth_pkg::HEAP_DEPTH_DEF;
   localparam int TIME_W      = dth_pkg::TIME_BITS_DEF;
   localparam int TAG_W       = dth_pkg::TAG_BITS_DEF;
   localparam int CNT_W       = $clog2(DEPTH + 1);
   localparam int ITEM_TARGET = 470;
   localparam int HOLD_AT     = 180;
   localparam int HOLD_CYCLES = 400;
   localparam int SETTLE      = 64;
   localparam int CYCLE_LIMIT = 4000000;

   typedef struct packed {
      dth_pkg::status_type status;
      logic [TAG_W-1:0]    tag;
      logic [TIME_W-1:0]   next_deadline;
      logic [CNT_W-1:0]    count;
      logic                last;
   } timer_result_type;

   // Predicts results from an ordered copy of the held timers. Keys are
   // {deadline, tag}, so plain unsigned order is the heap order.
   class deadline_ledger;
      logic [TIME_W+TAG_W-1:0] held_timers[$];
      logic [TIME_W-1:0]       clock_now;
      timer_result_type        pending_results[$];
      int                      mismatches;

      function new();
         clock_now = '0;
         mismatches = 0;
      endfunction

      task report_mismatch(string what);
         $display("[%0t] mismatch: %s", $realtime, what);
         mismatches++;
      endtask

      function void queue_result(dth_pkg::status_type status, logic [TAG_W-1:0] tag);
         timer_result_type r;
         r.status = status;
         r.tag = tag;
         r.next_deadline = (held_timers.size() > 0) ?
                           held_timers[0][TIME_W+TAG_W-1:TAG_W] : '1;
         r.count = CNT_W'(held_timers.size());
         r.last = 1'b0;
         pending_results.insert(pending_results.size(), r);
      endfunction

      function void note_request(logic action, logic [TIME_W-1:0] tv, logic [TAG_W-1:0] tag);
         int first;
         int pos;
         logic [TIME_W+TAG_W-1:0] key;
         first = pending_results.size();
         key = {tv, tag};
         if (action == dth_pkg::ACT_PUSH) begin
            if (tv <= clock_now) begin
               queue_result(dth_pkg::ST_PUSH_PAST, '0);
            end else if (held_timers.size() >= DEPTH) begin
               queue_result(dth_pkg::ST_PUSH_FULL, '0);
            end else begin
               pos = 0;
               while (pos < held_timers.size() && held_timers[pos] <= key) pos++;
               held_timers.insert(pos, key);
               queue_result(dth_pkg::ST_PUSH_OK, '0);
            end
         end else begin
            if (tv > clock_now) clock_now = tv;
            while (held_timers.size() > 0 &&
                   held_timers[0][TIME_W+TAG_W-1:TAG_W] <= clock_now) begin
               key = held_timers.pop_front();
               queue_result(dth_pkg::ST_EXPIRED, key[TAG_W-1:0]);
            end
            if (pending_results.size() == first) queue_result(dth_pkg::ST_NONE_DUE, '0);
         end
         pending_results[pending_results.size() - 1].last = 1'b1;
      endfunction

      task check_result(logic [2:0] status, logic [TAG_W-1:0] tag,
                        logic [TIME_W-1:0] next_deadline,
                        logic [CNT_W-1:0] count, logic last);
         timer_result_type exp_r;
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result status %0d with no transaction pending",
                                      status));
            return;
         end
         exp_r = pending_results.pop_front();
         if (status !== exp_r.status)
            report_mismatch($sformatf("status %0d, expected %0d", status, exp_r.status));
         if (tag !== exp_r.tag)
            report_mismatch($sformatf("expired_tag %0d, expected %0d", tag, exp_r.tag));
         if (next_deadline !== exp_r.next_deadline)
            report_mismatch($sformatf("next_deadline %h, expected %h",
                                      next_deadline, exp_r.next_deadline));
         if (count !== exp_r.count)
            report_mismatch($sformatf("entry_count %0d, expected %0d", count, exp_r.count));
         if (last !== exp_r.last)
            report_mismatch($sformatf("last %0d, expected %0d", last, exp_r.last));
      endtask
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_action = dth_pkg::ACT_PUSH;
   logic [TIME_W-1:0] req_time_value = '0;
   logic [TAG_W-1:0]  req_entry_tag = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [2:0]        rsp_status;
   logic [TAG_W-1:0]  rsp_expired_tag;
   logic [TIME_W-1:0] rsp_next_deadline;
   logic [CNT_W-1:0]  rsp_entry_count;
   logic              rsp_last;

   deadline_ledger ledger;
   int             sent_count = 0;
   int             burst_left = 0;
   bit             hold_done = 1'b0;

   deadline_timer_heap u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_time_value    (req_time_value),
      .req_entry_tag     (req_entry_tag),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_expired_tag   (rsp_expired_tag),
      .rsp_next_deadline (rsp_next_deadline),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_last          (rsp_last)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Offers one transaction and returns at the edge that accepts it.
   task automatic offer(logic action, logic [TIME_W-1:0] tv, logic [TAG_W-1:0] tag);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 40);
      end
      req_valid <= 1'b1;
      req_action <= action;
      req_time_value <= tv;
      req_entry_tag <= tag;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      ledger.note_request(action, tv, tag);
      sent_count++;
      burst_left--;
   endtask

   function automatic logic [TIME_W-1:0] ahead_of_clock(int unsigned lo, int unsigned hi);
      logic [TIME_W:0] sum;
      sum = {1'b0, ledger.clock_now} + $urandom_range(lo, hi);
      return sum[TIME_W] ? '1 : sum[TIME_W-1:0];
   endfunction

   function automatic logic [TIME_W-1:0] behind_clock();
      int unsigned back;
      back = $urandom_range(0, 20);
      return (ledger.clock_now > back) ? ledger.clock_now - back : '0;
   endfunction

   task automatic random_traffic();
      int unsigned span;
      int          pushes;
      int          pick;
      logic [TIME_W-1:0] tv;
      while (sent_count < ITEM_TARGET) begin
         case ($urandom_range(0, 3))
            0: span = 8;
            1: span = 256;
            2: span = 1 << 16;
            default: span = 1 << 24;
         endcase
         // Some episodes push up to 40 timers, more than the heap holds.
         pushes = ($urandom_range(0, 99) < 15) ? $urandom_range(30, 40)
                                               : $urandom_range(0, 10);
         repeat (pushes) begin
            pick = $urandom_range(0, 99);
            if (pick < 6) tv = $urandom;
            else if (pick < 12) tv = behind_clock();
            else tv = ahead_of_clock(1, span);
            offer(dth_pkg::ACT_PUSH, tv, TAG_W'($urandom_range(0, 255)));
         end
         pick = $urandom_range(0, 99);
         if (pick < 10) tv = behind_clock();
         else if (pick < 14) tv = $urandom;
         else tv = ahead_of_clock(0, span);
         offer(dth_pkg::ACT_ADVANCE, tv, TAG_W'($urandom_range(0, 255)));
      end
   endtask

   // Receiver: stretches of free flow, light and heavy stalling, and one long hold-off.
   initial begin
      int mode;
      int len;
      int i;
      wait (reset == 1'b0);
      forever begin
         if (!hold_done && sent_count >= HOLD_AT) begin
            rsp_stall <= 1'b1;
            for (i = 0; i < HOLD_CYCLES; i++) @(posedge clock);
            hold_done = 1'b1;
         end else begin
            mode = $urandom_range(0, 2);
            len = $urandom_range(4, 40);
            for (i = 0; i < len; i++) begin
               case (mode)
                  0: rsp_stall <= 1'b0;
                  1: rsp_stall <= $urandom_range(0, 1);
                  default: rsp_stall <= ($urandom_range(0, 7) != 0);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         ledger.check_result(rsp_status, rsp_expired_tag, rsp_next_deadline,
                             rsp_entry_count, rsp_last);
   end

   initial begin
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      ledger = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty queue, a deadline equal to the clock, and the widest values.
      offer(dth_pkg::ACT_ADVANCE, '0, 8'h33);
      offer(dth_pkg::ACT_PUSH, '0, 8'h5A);
      offer(dth_pkg::ACT_PUSH, '1, 8'hFF);
      // Equal deadlines must leave smallest tag first.
      offer(dth_pkg::ACT_PUSH, 32'd10, 8'h80);
      offer(dth_pkg::ACT_PUSH, 32'd10, 8'h7F);
      offer(dth_pkg::ACT_PUSH, 32'd10, 8'h00);
      offer(dth_pkg::ACT_PUSH, 32'd5, 8'h01);
      offer(dth_pkg::ACT_ADVANCE, 32'd7, 8'h00);
      // Moving backwards keeps the clock where it is.
      offer(dth_pkg::ACT_ADVANCE, 32'd3, 8'hC3);
      offer(dth_pkg::ACT_PUSH, 32'd7, 8'h03);
      offer(dth_pkg::ACT_PUSH, 32'd6, 8'h04);
      offer(dth_pkg::ACT_ADVANCE, 32'd10, 8'h00);
      offer(dth_pkg::ACT_PUSH, 32'd12, 8'hAA);
      offer(dth_pkg::ACT_PUSH, 32'd11, 8'h55);
      offer(dth_pkg::ACT_ADVANCE, 32'd5, 8'h00);
      offer(dth_pkg::ACT_ADVANCE, 32'd20, 8'h00);

      random_traffic();
      // Advancing to the end of time drains everything still held.
      offer(dth_pkg::ACT_ADVANCE, '1, 8'h00);
      req_valid <= 1'b0;

      while (ledger.pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (ledger.mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl
rtl/dth_pkg.sv
rtl/dth_cmp.sv
rtl/dth_core.sv
rtl/deadline_timer_heap.sv
rtl/dth_checker.sv
verif/deadline_timer_heap_test.sv
